>>> rtl/tswm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tswm_pkg;

    // Slot storage default
    localparam int DATA_SLOTS_DEFAULT = 7;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int CODE_W   = 7;
    localparam int SLOT_W   = 6;
    localparam int VALUE_W  = 10;
    localparam int INDEX_W  = 16;
    localparam int FLAG_W   = 5;
    localparam int BOUND_W  = 11;

    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [FLAG_W-1:0]  flags_t;
    typedef logic [BOUND_W-1:0] bound_t;

    // Monitored codes
    localparam code_t CODE_Q0 = 7'd70;
    localparam code_t CODE_Q1 = 7'd79;
    localparam code_t CODE_Q2 = 7'd101;
    localparam code_t CODE_Q3 = 7'd105;
    localparam code_t CODE_Q4 = 7'd111;

    // Open window bounds, both excluded
    localparam bound_t Q0_LO = 11'd350;
    localparam bound_t Q0_HI = 11'd650;
    localparam bound_t Q1_LO = 11'd400;
    localparam bound_t Q1_HI = 11'd900;
    localparam bound_t Q2_LO = 11'd400;
    localparam bound_t Q2_HI = 11'd900;
    localparam bound_t Q3_LO = 11'd800;
    localparam bound_t Q3_HI = 11'd1050;
    localparam bound_t Q4_LO = 11'd300;
    localparam bound_t Q4_HI = 11'd700;

    // One-hot flag select for a monitored code, zero for any other code
    function automatic flags_t window_mask(input code_t code);
        flags_t mask;
        unique case (code)
            CODE_Q0: mask = 5'b00001;
            CODE_Q1: mask = 5'b00010;
            CODE_Q2: mask = 5'b00100;
            CODE_Q3: mask = 5'b01000;
            CODE_Q4: mask = 5'b10000;
            default: mask = '0;
        endcase
        return mask;
    endfunction

    // Strict window test of a value against the window of a code
    function automatic logic in_window(input code_t code, input value_t value);
        bound_t lo;
        bound_t hi;
        bound_t v;
        v = {1'b0, value};
        unique case (code)
            CODE_Q0: begin lo = Q0_LO; hi = Q0_HI; end
            CODE_Q1: begin lo = Q1_LO; hi = Q1_HI; end
            CODE_Q2: begin lo = Q2_LO; hi = Q2_HI; end
            CODE_Q3: begin lo = Q3_LO; hi = Q3_HI; end
            CODE_Q4: begin lo = Q4_LO; hi = Q4_HI; end
            default: begin lo = '0; hi = '0; end
        endcase
        return (v > lo) && (v < hi);
    endfunction

endpackage

`default_nettype wire

>>> rtl/telemetry_stream_window_monitor_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Telemetry stream window monitor. Each transfer on the s_ channel carries one
// stream byte: a byte with bit 7 set stores its low six bits in the next free
// data slot (bytes beyond the last slot are dropped, no record), any other
// byte emits one record on the m_ channel with the preceding code, the 10-bit
// value built from slots one and two, the first three raw slots, a running
// 16-bit record index and the five window OK flags after checking the value
// against the preceding code's open window; a zero byte marks end of block.
// A byte is taken every cycle: it goes through one input register and then one
// result register before its record is offered on the m_ channel, and a stalled
// m_ side blocks the input only once both registers hold a record-producing
// item. Data bytes never wait on the m_ side.
module telemetry_stream_window_monitor_core #(
    parameter int DATA_SLOTS = tswm_pkg::DATA_SLOTS_DEFAULT
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire  [tswm_pkg::BYTE_W-1:0]     s_stream_byte,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic [tswm_pkg::INDEX_W-1:0]    m_record_index,
    output logic [tswm_pkg::CODE_W-1:0]     m_code,
    output logic [tswm_pkg::VALUE_W-1:0]    m_value,
    output logic [tswm_pkg::SLOT_W-1:0]     m_slot_one,
    output logic [tswm_pkg::SLOT_W-1:0]     m_slot_two,
    output logic [tswm_pkg::SLOT_W-1:0]     m_slot_three,
    output logic [tswm_pkg::FLAG_W-1:0]     m_window_flags,
    output logic                            m_source_ok,
    output logic                            m_end_of_block
);

    localparam int COUNT_W = $clog2(DATA_SLOTS + 1);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DATA_SLOTS);

    // Input register
    logic                          in_valid_reg;
    logic [tswm_pkg::BYTE_W-1:0]   in_byte_reg;

    // Block state
    logic [COUNT_W-1:0]            slot_count_reg;
    logic [COUNT_W-1:0]            slot_count_next;
    tswm_pkg::slot_t               slots_reg [DATA_SLOTS];
    tswm_pkg::code_t               last_code_reg;
    tswm_pkg::flags_t              ok_flags_reg;
    tswm_pkg::flags_t              ok_flags_next;
    logic [tswm_pkg::INDEX_W-1:0]  record_count_reg;

    // Result register
    logic                          out_valid_reg;
    logic [tswm_pkg::INDEX_W-1:0]  out_index_reg;
    tswm_pkg::code_t               out_code_reg;
    tswm_pkg::value_t              out_value_reg;
    tswm_pkg::slot_t               out_slot_one_reg;
    tswm_pkg::slot_t               out_slot_two_reg;
    tswm_pkg::slot_t               out_slot_three_reg;
    tswm_pkg::flags_t              out_flags_reg;
    logic                          out_eob_reg;

    logic                          is_data;
    logic                          proc_go;
    logic                          emit;
    tswm_pkg::value_t              value;
    tswm_pkg::flags_t              mask;

    // Classify the held byte and decide whether it moves on this cycle
    assign is_data = in_byte_reg[tswm_pkg::BYTE_W-1];
    assign proc_go = in_valid_reg && (is_data || !out_valid_reg || m_ready);
    assign emit    = proc_go && !is_data;
    assign s_ready = !in_valid_reg || proc_go;

    // Build value from slot one low nibble and slot two
    assign value = {slots_reg[0][3:0], slots_reg[1]};

    // Window check against the code the data belongs to
    assign mask = tswm_pkg::window_mask(last_code_reg);

    always_comb begin
        ok_flags_next = ok_flags_reg;
        if (tswm_pkg::in_window(last_code_reg, value)) begin
            ok_flags_next = ok_flags_reg | mask;
        end else begin
            ok_flags_next = ok_flags_reg & ~mask;
        end
    end

    // Advance slot counter, saturate at full, rewind on a code byte
    always_comb begin
        slot_count_next = slot_count_reg;
        if (proc_go) begin
            if (!is_data) begin
                slot_count_next = '0;
            end else if (slot_count_reg < COUNT_FULL) begin
                slot_count_next = slot_count_reg + COUNT_W'(1);
            end
        end
    end

    // Hold the incoming byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_stream_byte;
        end
    end

    // Update block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg   <= '0;
            last_code_reg    <= '0;
            ok_flags_reg     <= '0;
            record_count_reg <= '0;
            for (int i = 0; i < DATA_SLOTS; i++) begin
                slots_reg[i] <= '0;
            end
        end else begin
            slot_count_reg <= slot_count_next;
            if (proc_go && is_data) begin
                for (int i = 0; i < DATA_SLOTS; i++) begin
                    if (slot_count_reg == COUNT_W'(i)) begin
                        slots_reg[i] <= in_byte_reg[tswm_pkg::SLOT_W-1:0];
                    end
                end
            end
            if (emit) begin
                last_code_reg    <= in_byte_reg[tswm_pkg::CODE_W-1:0];
                ok_flags_reg     <= ok_flags_next;
                record_count_reg <= record_count_reg + tswm_pkg::INDEX_W'(1);
            end
        end
    end

    // Result register valid: load on emit, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_index_reg      <= record_count_reg;
            out_code_reg       <= last_code_reg;
            out_value_reg      <= value;
            out_slot_one_reg   <= slots_reg[0];
            out_slot_two_reg   <= slots_reg[1];
            out_slot_three_reg <= slots_reg[2];
            out_flags_reg      <= ok_flags_next;
            out_eob_reg        <= (in_byte_reg == '0);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_record_index = out_index_reg;
    assign m_code         = out_code_reg;
    assign m_value        = out_value_reg;
    assign m_slot_one     = out_slot_one_reg;
    assign m_slot_two     = out_slot_two_reg;
    assign m_slot_three   = out_slot_three_reg;
    assign m_window_flags = out_flags_reg;
    assign m_source_ok    = &out_flags_reg;
    assign m_end_of_block = out_eob_reg;

`ifndef NO_ASSERTIONS
    // Slot counter never passes the slot count
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_count_reg <= COUNT_FULL)
        else $error("slot counter beyond slot storage");

    // A code byte always produces a pending record
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid)
        else $error("code byte did not produce a record");

    // Data bytes leave record count and flags untouched
    a_data_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_go && is_data) |=> ($stable(record_count_reg) && $stable(ok_flags_reg)))
        else $error("data byte changed record state");

    // A pending record is never overwritten before its transfer
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !emit)
        else $error("pending record overwritten");

    // A code byte rewinds the slot counter
    a_rewind: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (slot_count_reg == '0))
        else $error("slot counter not rewound on code byte");
`endif

endmodule

`default_nettype wire
